// File: hw/rtl/swpd_pkg.sv
package swpd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam int PAYLOAD_LEN = 20;
  localparam int IDX_W       = $clog2(PAYLOAD_LEN);
  localparam int PAY_W       = (PAYLOAD_LEN - 1) * 8;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_LEN - 1);

  typedef struct packed {
    logic [31:0] quat_z;
    logic [31:0] quat_y;
    logic [31:0] quat_x;
    logic [31:0] quat_w;
    logic [31:0] seq_number;
  } pkt_t;

endpackage

// File: hw/rtl/swpd_front.sv
module swpd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  output logic            push_valid,
  input  logic            push_ready,
  output swpd_pkg::pkt_t  push_pkt
);
  import swpd_pkg::*;

  typedef enum logic [1:0] {HUNT, ARMED, DATA} state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [PAY_W-1:0] pay_r;
  logic             completing;
  logic             in_fire;

  assign completing = (state_r == DATA) && (idx_r == IDX_LAST);
  assign in_ready   = !(completing && !push_ready);
  assign in_fire    = in_valid && in_ready;
  assign push_valid = in_valid && completing;
  assign push_pkt   = pkt_t'({in_rx_byte, pay_r});

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    if (in_fire) begin
      case (state_r)
        HUNT: begin
          state_nxt = (in_rx_byte == SYNC_FIRST) ? ARMED : HUNT;
        end
        ARMED: begin
          if (in_rx_byte == SYNC_SECOND) begin
            state_nxt = DATA;
            idx_nxt   = '0;
          end else if (in_rx_byte != SYNC_FIRST) begin
            state_nxt = HUNT;
          end
        end
        DATA: begin
          if (idx_r == IDX_LAST) begin
            state_nxt = HUNT;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        default: begin
          state_nxt = HUNT;
          idx_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HUNT;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // shift payload in; byte 0 ends at the low end
  always_ff @(posedge clk) begin
    if (in_fire && (state_r == DATA)) begin
      pay_r <= {in_rx_byte, pay_r[PAY_W-1:8]};
    end
  end

  a_last_byte_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && completing) |=> (state_r == HUNT) && (idx_r == '0))
    else $error("front did not return to hunting after last payload byte");

  a_sync_enters_data: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (state_r == ARMED) && (in_rx_byte == SYNC_SECOND))
      |=> (state_r == DATA) && (idx_r == '0))
    else $error("sync word did not start payload collection");

endmodule

// File: hw/rtl/swpd_fifo.sv
module swpd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  swpd_pkg::pkt_t  push_pkt,
  output logic            pop_valid,
  input  logic            pop_ready,
  output swpd_pkg::pkt_t  pop_pkt
);
  import swpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pkt_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_pkt    = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

// File: hw/rtl/swpd_back.sv
module swpd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  swpd_pkg::pkt_t  pop_pkt,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_seq_number,
  output logic [31:0]     out_quat_w,
  output logic [31:0]     out_quat_x,
  output logic [31:0]     out_quat_y,
  output logic [31:0]     out_quat_z,
  output logic [31:0]     out_seq_gap,
  output logic [31:0]     out_packets_seen,
  output logic [31:0]     out_packets_missed
);
  import swpd_pkg::*;

  logic        out_valid_r;
  pkt_t        pkt_r;
  logic [31:0] gap_r, gap_nxt;
  logic [31:0] expect_r;
  logic        first_r;
  logic [31:0] seen_r, seen_nxt;
  logic [31:0] missed_r, missed_nxt;
  logic [32:0] missed_sum;
  logic        pop_fire;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop_fire  = pop_valid && pop_ready;

  always_comb begin
    gap_nxt    = first_r ? 32'd0 : (pop_pkt.seq_number - expect_r);
    missed_sum = {1'b0, missed_r} + {1'b0, gap_nxt};
    missed_nxt = missed_sum[32] ? '1 : missed_sum[31:0];
    seen_nxt   = (seen_r == '1) ? seen_r : seen_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      expect_r    <= '0;
      first_r     <= 1'b1;
      seen_r      <= '0;
      missed_r    <= '0;
    end else begin
      if (pop_fire) begin
        out_valid_r <= 1'b1;
        expect_r    <= pop_pkt.seq_number + 1'b1;
        first_r     <= 1'b0;
        seen_r      <= seen_nxt;
        missed_r    <= missed_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      pkt_r <= pop_pkt;
      gap_r <= gap_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_seq_number     = pkt_r.seq_number;
  assign out_quat_w         = pkt_r.quat_w;
  assign out_quat_x         = pkt_r.quat_x;
  assign out_quat_y         = pkt_r.quat_y;
  assign out_quat_z         = pkt_r.quat_z;
  assign out_seq_gap        = gap_r;
  assign out_packets_seen   = seen_r;
  assign out_packets_missed = missed_r;

  a_first_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && first_r) |=> (gap_r == '0) && (seen_r == 32'd1))
    else $error("first packet has nonzero gap or wrong count");

endmodule

// File: hw/rtl/sync_word_packet_deframer_unit.sv
// Path: the last payload byte is written into the record queue when it is accepted,
//   and the record is then loaded into the output register that drives out_.
// Throughput: one byte per cycle; in_ready drops only while the front waits on a
//   packet's last byte and the record queue is full.
// Reset: synchronous, active low; clears the sync hunter, counters, queue and
//   output valid. The payload shift register and queue entries are not reset.
module sync_word_packet_deframer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_seq_number,
  output logic [31:0] out_quat_w,
  output logic [31:0] out_quat_x,
  output logic [31:0] out_quat_y,
  output logic [31:0] out_quat_z,
  output logic [31:0] out_seq_gap,
  output logic [31:0] out_packets_seen,
  output logic [31:0] out_packets_missed
);
  import swpd_pkg::*;

  logic push_valid, push_ready;
  pkt_t push_pkt;
  logic pop_valid, pop_ready;
  pkt_t pop_pkt;

  swpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pkt   (push_pkt)
  );

  swpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pkt   (push_pkt),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_pkt    (pop_pkt)
  );

  swpd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_pkt            (pop_pkt),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_seq_number     (out_seq_number),
    .out_quat_w         (out_quat_w),
    .out_quat_x         (out_quat_x),
    .out_quat_y         (out_quat_y),
    .out_quat_z         (out_quat_z),
    .out_seq_gap        (out_seq_gap),
    .out_packets_seen   (out_packets_seen),
    .out_packets_missed (out_packets_missed)
  );

endmodule
